@@ hdl/ring_buffer_deque_macros.svh @@
// assertion macros for the ring buffer deque
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

`ifndef SYNTHESIS

`define RBD_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("deque assertion failed");

`define RBD_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("deque assertion failed");

`else

`define RBD_ASSERT_IMPLIES(label, clk, rst, cond, expr)

`define RBD_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

@@ hdl/rbd_pkg.sv @@
// shared types and codes for the ring buffer deque
`default_nettype none

package rbd_pkg;

  localparam int WORD_W = 32;
  localparam int KIND_W = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W = 11;
  localparam int CAP_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  push;
    logic  at_front;
    word_t value;
  } op_t;

endpackage

`default_nettype wire

@@ hdl/rbd_front.sv @@
// front end: decodes incoming words and queues them for the back end
`default_nettype none

module rbd_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [rbd_pkg::KIND_W-1:0] kind,
  input  wire rbd_pkg::word_t             push_value,
  output logic                            op_valid,
  output rbd_pkg::op_t                    op
);
  import rbd_pkg::*;

  op_t        q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic [1:0] fill_next;
  op_t        dec;
  logic       accept;

  always_comb begin
    dec.value = push_value;
    dec.push = 1'b0;
    dec.at_front = 1'b0;
    unique case (kind)
      KIND_PUSH_FRONT: begin
        dec.push = 1'b1;
        dec.at_front = 1'b1;
      end
      KIND_PUSH_BACK: begin
        dec.push = 1'b1;
        dec.at_front = 1'b0;
      end
      KIND_POP_FRONT: begin
        dec.push = 1'b0;
        dec.at_front = 1'b1;
      end
      KIND_POP_BACK: begin
        dec.push = 1'b0;
        dec.at_front = 1'b0;
      end
      default: begin
        dec.push = 1'b0;
        dec.at_front = 1'b0;
      end
    endcase
  end

  assign busy = (fill == 2'd2);
  assign accept = start && !busy;
  assign op_valid = (fill != 2'd0);
  assign op = q[rd_ptr];

  // back end drains one word every cycle the queue holds one
  always_comb begin
    fill_next = fill;
    if (accept && !op_valid) begin
      fill_next = fill + 2'd1;
    end else if (!accept && op_valid) begin
      fill_next = fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      fill <= fill_next;
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (op_valid) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= dec;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rbd_back.sv @@
// back end: index and count update, circular store and result register
`default_nettype none

module rbd_back #(
  parameter int DEPTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        op_valid,
  input  wire rbd_pkg::op_t                op,
  input  wire logic [rbd_pkg::CAP_W-1:0]   capacity,
  output logic                             done,
  output rbd_pkg::word_t                   pop_value,
  output logic [rbd_pkg::STATUS_W-1:0]     status,
  output logic [rbd_pkg::OCC_W-1:0]        occupancy
);
  import rbd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  word_t               mem [DEPTH];
  word_t               rd_data;
  logic [AW-1:0]       front_index;
  logic [AW-1:0]       back_index;
  logic [CW-1:0]       entry_count;
  logic [AW-1:0]       front_index_next;
  logic [AW-1:0]       back_index_next;
  logic [CW-1:0]       entry_count_next;
  logic [AW-1:0]       addr;
  logic                wr_en;
  logic                rd_en;
  logic [STATUS_W-1:0] st;
  logic [LW-1:0]       limit;
  logic                full;
  logic                empty;
  logic                popped;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - AW'(1);
  endfunction

  // capacity above the store depth saturates
  assign limit = (LW'(capacity) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(capacity);
  assign full = (LW'(entry_count) >= limit);
  assign empty = (entry_count == '0);

  always_comb begin
    front_index_next = front_index;
    back_index_next = back_index;
    entry_count_next = entry_count;
    addr = back_index;
    wr_en = 1'b0;
    rd_en = 1'b0;
    st = ST_DONE;
    if (op_valid) begin
      if (op.push) begin
        if (full) begin
          st = ST_FULL;
        end else begin
          wr_en = 1'b1;
          entry_count_next = entry_count + CW'(1);
          if (op.at_front) begin
            front_index_next = idx_dec(front_index);
            addr = front_index_next;
          end else begin
            addr = back_index;
            back_index_next = idx_inc(back_index);
          end
        end
      end else begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          rd_en = 1'b1;
          entry_count_next = entry_count - CW'(1);
          if (op.at_front) begin
            addr = front_index;
            front_index_next = idx_inc(front_index);
          end else begin
            back_index_next = idx_dec(back_index);
            addr = back_index_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index <= '0;
      entry_count <= '0;
      done <= 1'b0;
      popped <= 1'b0;
    end else begin
      front_index <= front_index_next;
      back_index <= back_index_next;
      entry_count <= entry_count_next;
      done <= op_valid;
      popped <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    status <= st;
    occupancy <= OCC_W'(entry_count_next);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= op.value;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  assign pop_value = popped ? rd_data : '0;

endmodule

`default_nettype wire

@@ hdl/ring_buffer_deque.sv @@
// top level of the ring buffer deque with its configuration port
//
//   channel   handshake                 payload
//   command   start in, busy out        kind, push_value
//   result    done out (one cycle)      pop_value, status, occupancy
//   config    apb psel/penable/pready   paddr, pwdata, prdata (capacity)
//
// one word per cycle sustained; after the start edge a command is held in
// the command queue register, then the back end registers done, the result
// and the store read together
// the store is not cleared: only written entries are ever read back
// rst is synchronous and clears indices, count, queue and capacity
// the receiver cannot stall; busy rises only when the command queue fills
`default_nettype none

module ring_buffer_deque #(
  parameter int DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [rbd_pkg::KIND_W-1:0]   kind,
  input  wire rbd_pkg::word_t               push_value,
  output logic                              done,
  output rbd_pkg::word_t                    pop_value,
  output logic [rbd_pkg::STATUS_W-1:0]      status,
  output logic [rbd_pkg::OCC_W-1:0]         occupancy,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [1:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import rbd_pkg::*;

  `include "ring_buffer_deque_macros.svh"

  logic             op_valid;
  op_t              op;
  logic [CAP_W-1:0] capacity;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  // single register, every address maps to it
  assign prdata = {{(32 - CAP_W){1'b0}}, capacity} | {30'd0, paddr & 2'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  rbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .push_value (push_value),
    .op_valid   (op_valid),
    .op         (op)
  );

  rbd_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op        (op),
    .capacity  (capacity),
    .done      (done),
    .pop_value (pop_value),
    .status    (status),
    .occupancy (occupancy)
  );

  `RBD_ASSERT_IMPLIES(a_refused_zero, clk, rst, done && status != ST_DONE, pop_value == '0)
  `RBD_ASSERT_IMPLIES(a_empty_occ, clk, rst, done && status == ST_EMPTY, occupancy == '0)
  `RBD_ASSERT_NEXT(a_queued_result, clk, rst, op_valid, done)
  `RBD_ASSERT_IMPLIES(a_busy_cause, clk, rst, $rose(busy), $past(start))

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// self-checking testbench for the ring buffer deque: directed and random words, apb capacity
module testbench;
  import rbd_pkg::*;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    word_t                value;
    logic [STATUS_W-1:0]  st;
    logic [OCC_W-1:0]     occ;
  } outcome_t;

  class deque_shadow;
    word_t              slots [DEPTH];
    logic [9:0]         head;
    logic [9:0]         tail;
    logic [OCC_W-1:0]   held;
    logic [CAP_W-1:0]   cap;
    outcome_t           awaited [$];
    int                 errors;

    function new();
      head = '0;
      tail = '0;
      held = '0;
      cap = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      cap = c;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // indices are 10 bits wide so they wrap modulo the store depth
    function void note_command(logic [KIND_W-1:0] k, word_t v);
      outcome_t o;
      logic [OCC_W-1:0] limit;
      limit = (cap > DEPTH) ? OCC_W'(DEPTH) : cap;
      o.value = '0;
      o.st = ST_DONE;
      case (k) inside
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (held >= limit) begin
            o.st = ST_FULL;
          end else if (k == KIND_PUSH_FRONT) begin
            head = head - 1'b1;
            slots[head] = v;
            held = held + 1'b1;
          end else begin
            slots[tail] = v;
            tail = tail + 1'b1;
            held = held + 1'b1;
          end
        end
        KIND_POP_FRONT: begin
          if (held == 0) begin
            o.st = ST_EMPTY;
          end else begin
            o.value = slots[head];
            head = head + 1'b1;
            held = held - 1'b1;
          end
        end
        default: begin
          if (held == 0) begin
            o.st = ST_EMPTY;
          end else begin
            tail = tail - 1'b1;
            o.value = slots[tail];
            held = held - 1'b1;
          end
        end
      endcase
      o.occ = held;
      awaited.insert(awaited.size(), o);
    endfunction

    task flag(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_word(word_t pv, logic [STATUS_W-1:0] st, logic [OCC_W-1:0] occ);
      outcome_t o;
      if (awaited.size() == 0) begin
        flag("result word with nothing expected");
      end else begin
        o = awaited[0];
        awaited.delete(0);
        if (pv !== o.value)
          flag($sformatf("pop_value %h, expected %h", pv, o.value));
        if (st !== o.st)
          flag($sformatf("status %0d, expected %0d", st, o.st));
        if (occ !== o.occ)
          flag($sformatf("occupancy %0d, expected %0d", occ, o.occ));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [KIND_W-1:0]    kind = KIND_PUSH_FRONT;
  word_t                push_value = '0;
  logic                 done;
  word_t                pop_value;
  logic [STATUS_W-1:0]  status;
  logic [OCC_W-1:0]     occupancy;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [1:0]           paddr = 2'd0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  deque_shadow book = new();
  int idle_pct = 24;
  int cycles = 0;

  ring_buffer_deque #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .push_value(push_value), .done(done), .pop_value(pop_value), .status(status),
    .occupancy(occupancy), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) book.check_word(pop_value, status, occupancy);
  end

  task send_word(logic [KIND_W-1:0] k, word_t v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    push_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    book.note_command(k, v);
  endtask

  // only between phases, once every result word has come back
  task write_capacity(logic [CAP_W-1:0] c);
    logic [31:0] data;
    data = ($urandom() & 32'hFFFF_F800) | 32'(c);
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    book.set_capacity(c);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CAP_W-1:0] !== c)
      book.flag($sformatf("capacity read %0d, expected %0d", prdata[CAP_W-1:0], c));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function word_t pick_value();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task run_phase(int count, int push_pct);
    logic [KIND_W-1:0] k;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < push_pct)
        k = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      else
        k = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
      send_word(k, pick_value());
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [8];
    int counts [8];
    int bias [8];
    caps = '{11'd1, 11'd2, 11'd0, 11'd7, 11'd1024, 11'd3, 11'd64, 11'd0};
    counts = '{50, 50, 30, 50, 120, 50, 50, 50};
    bias = '{60, 45, 60, 55, 50, 35, 65, 50};
    caps[7] = CAP_W'($urandom_range(1024, 1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty pops, extremes, and both indices wrapping in each direction
    send_word(KIND_POP_FRONT, 32'h1234_5678);
    send_word(KIND_POP_BACK, 32'hFFFF_FFFF);
    send_word(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
    send_word(KIND_PUSH_BACK, 32'h8000_0000);
    send_word(KIND_PUSH_FRONT, 32'h0000_0000);
    send_word(KIND_PUSH_BACK, 32'hFFFF_FFFF);
    send_word(KIND_POP_FRONT, 32'h0);
    send_word(KIND_POP_FRONT, 32'h0);
    send_word(KIND_POP_BACK, 32'h0);
    send_word(KIND_POP_BACK, 32'h0);
    send_word(KIND_PUSH_FRONT, 32'hA5A5_A5A5);
    send_word(KIND_POP_BACK, 32'h0);
    send_word(KIND_PUSH_BACK, 32'h5A5A_5A5A);
    send_word(KIND_POP_FRONT, 32'h0);
    send_word(KIND_PUSH_BACK, 32'h0000_0001);
    send_word(KIND_PUSH_BACK, 32'h0000_0002);
    send_word(KIND_PUSH_BACK, 32'h0000_0003);
    // capacity below occupancy, then zero
    write_capacity(11'd1);
    send_word(KIND_PUSH_FRONT, 32'hDEAD_BEEF);
    send_word(KIND_PUSH_BACK, 32'hCAFE_F00D);
    send_word(KIND_POP_FRONT, 32'h0);
    write_capacity(11'd0);
    send_word(KIND_PUSH_BACK, 32'h0BAD_F00D);
    send_word(KIND_POP_BACK, 32'h0);
    send_word(KIND_POP_BACK, 32'h0);
    send_word(KIND_POP_FRONT, 32'h0);

    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      idle_pct = (caps[p] == 11'd1024) ? 0 : 24;
      run_phase(counts[p], bias[p]);
    end

    // capacity above depth saturates
    idle_pct = 24;
    write_capacity(11'd2047);
    run_phase(80, 60);

    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hdl
hdl/rbd_pkg.sv
hdl/rbd_front.sv
hdl/rbd_back.sv
hdl/ring_buffer_deque.sv
test/testbench.sv
